>>> sv/kpdtg_pkg.sv
// Package for the keypad scanner and dual-tone generator.
// Holds the count width, tone tables, key table and shared control types.
// No dependencies.
`timescale 1ns / 1ps

package kpdtg_pkg;

   localparam int COUNT_WIDTH = 11;
   localparam logic [15:0] SCAN_PERIOD_RESET = 16'd7000;
   localparam logic [3:0] IDLE_LIMIT_RESET = 4'd4;
   localparam logic [3:0] IDLE_MAX = 4'd15;
   localparam logic [3:0] ROW_RESET = 4'b0010;
   localparam logic [3:0] ROW_FIRST = 4'b0001;
   localparam logic [3:0] ROW_LAST = 4'b1000;

   localparam logic CSR_SCAN_PERIOD = 1'b0;
   localparam logic CSR_IDLE_LIMIT = 1'b1;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam count_type ROW_HALF_TABLE [4] = '{
      COUNT_WIDTH'(827), COUNT_WIDTH'(749), COUNT_WIDTH'(677), COUNT_WIDTH'(612)
   };
   localparam count_type COLUMN_HALF_TABLE [4] = '{
      COUNT_WIDTH'(1435), COUNT_WIDTH'(1299), COUNT_WIDTH'(1174), COUNT_WIDTH'(1063)
   };
   localparam logic [6:0] KEY_TABLE [16] = '{
      7'h31, 7'h32, 7'h33, 7'h41,
      7'h34, 7'h35, 7'h36, 7'h42,
      7'h37, 7'h38, 7'h39, 7'h43,
      7'h2A, 7'h30, 7'h23, 7'h44
   };

   typedef struct packed {
      logic hit;
      logic [1:0] index;
   } onehot_type;

   typedef struct packed {
      logic advance;
      logic update;
      logic start;
   } tone_ctrl_type;

   typedef struct packed {
      logic [3:0] row_drive;
      logic key_valid;
      logic [6:0] key_char;
      count_type row_half;
      count_type column_half;
      tone_ctrl_type tone_ctrl;
   } scan_out_type;

   function automatic onehot_type onehot_decode(input logic [3:0] value);
      onehot_type result;
      result.hit = 1'b1;
      result.index = 2'd0;
      unique case (value)
         4'b0001: result.index = 2'd0;
         4'b0010: result.index = 2'd1;
         4'b0100: result.index = 2'd2;
         4'b1000: result.index = 2'd3;
         default: result.hit = 1'b0;
      endcase
      return result;
   endfunction

endpackage

>>> sv/keypad_scan_dual_tone_generator_unit.sv
// Top level of the keypad scanner and dual-tone generator.
// Depends on kpdtg_pkg, kpdtg_scan and kpdtg_tone.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_column_lines[3:0]
//   rsp      out        rsp_valid/rsp_ready  rsp_row_drive, rsp_row_tone,
//                                            rsp_column_tone, rsp_key_valid,
//                                            rsp_key_char
//   csr      in         csr_write_enable     csr_index, csr_write_data[15:0]
//
// Each tick updates the scan and tone state at the transfer, and its result
// appears in the output register on the next cycle.
// A new tick is taken every cycle while the output register is empty or drained.
// A stalled result holds; the tone levels change only on an input transfer.
// Synchronous reset restores the register defaults and clears all state but the output data registers.
`timescale 1ns / 1ps

module keypad_scan_dual_tone_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_column_lines,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_row_drive,
   output logic        rsp_row_tone,
   output logic        rsp_column_tone,
   output logic        rsp_key_valid,
   output logic [6:0]  rsp_key_char,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   logic [15:0] scan_period_ff;
   logic [3:0] idle_limit_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] row_drive_ff;
   logic key_valid_ff;
   logic [6:0] key_char_ff;
   logic accept;
   kpdtg_pkg::scan_out_type scan_out;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff <= kpdtg_pkg::SCAN_PERIOD_RESET;
         idle_limit_ff <= kpdtg_pkg::IDLE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            kpdtg_pkg::CSR_SCAN_PERIOD: scan_period_ff <= csr_write_data;
            kpdtg_pkg::CSR_IDLE_LIMIT: idle_limit_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   kpdtg_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .column_lines (req_column_lines),
      .scan_period  (scan_period_ff),
      .idle_limit   (idle_limit_ff),
      .scan_out     (scan_out)
   );

   kpdtg_tone u_row_tone (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_out.tone_ctrl),
      .new_half (scan_out.row_half),
      .level    (rsp_row_tone)
   );

   kpdtg_tone u_column_tone (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_out.tone_ctrl),
      .new_half (scan_out.column_half),
      .level    (rsp_column_tone)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_drive_ff <= scan_out.row_drive;
         key_valid_ff <= scan_out.key_valid;
         key_char_ff <= scan_out.key_char;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row_drive = row_drive_ff;
   assign rsp_key_valid = key_valid_ff;
   assign rsp_key_char = key_char_ff;

endmodule

>>> sv/kpdtg_tone.sv
// One square-wave tone channel: half period, countdown and output level.
// Depends on kpdtg_pkg for the count type and the tone control struct.
`timescale 1ns / 1ps

module kpdtg_tone (
   input  logic                      clock,
   input  logic                      reset,
   input  kpdtg_pkg::tone_ctrl_type  ctrl,
   input  kpdtg_pkg::count_type      new_half,
   output logic                      level
);

   kpdtg_pkg::count_type half_ff, half_in;
   kpdtg_pkg::count_type countdown_ff, countdown_in;
   logic level_ff, level_in;
   logic expire;

   assign expire = (countdown_ff <= kpdtg_pkg::count_type'(1));

   always_comb begin
      half_in = ctrl.update ? new_half : half_ff;
      level_in = level_ff;
      countdown_in = countdown_ff;
      if (ctrl.advance) begin
         if (expire) begin
            level_in = ~level_ff;
            countdown_in = half_ff;
         end else begin
            countdown_in = countdown_ff - kpdtg_pkg::count_type'(1);
         end
      end
      if (ctrl.start) begin
         countdown_in = new_half;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= '0;
         countdown_ff <= '0;
         level_ff <= 1'b0;
      end else begin
         half_ff <= half_in;
         countdown_ff <= countdown_in;
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

>>> sv/kpdtg_scan.sv
// Keypad scan control: row rotation, scan timer, idle count and key decode.
// Depends on kpdtg_pkg for tables, the one-hot decoder and the output struct.
`timescale 1ns / 1ps

module kpdtg_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [3:0]               column_lines,
   input  logic [15:0]              scan_period,
   input  logic [3:0]               idle_limit,
   output kpdtg_pkg::scan_out_type  scan_out
);

   logic [3:0] row_select_ff, row_select_in;
   logic [15:0] scan_timer_ff, scan_timer_in;
   logic [3:0] idle_count_ff, idle_count_in;
   logic tones_on_ff, tones_on_in;
   logic scan_due;
   logic key_hit;
   logic [3:0] idle_inc;
   kpdtg_pkg::onehot_type row_dec;
   kpdtg_pkg::onehot_type col_dec;

   assign scan_due = ({1'b0, scan_timer_ff} + 17'd1) >= {1'b0, scan_period};
   assign row_dec = kpdtg_pkg::onehot_decode(row_select_ff);
   assign col_dec = kpdtg_pkg::onehot_decode(column_lines);
   assign key_hit = scan_due && row_dec.hit && col_dec.hit;
   assign idle_inc = (idle_count_ff == kpdtg_pkg::IDLE_MAX) ? idle_count_ff
                     : idle_count_ff + 4'd1;

   always_comb begin
      row_select_in = row_select_ff;
      scan_timer_in = scan_timer_ff;
      idle_count_in = idle_count_ff;
      tones_on_in = tones_on_ff;
      if (accept) begin
         if (scan_due) begin
            scan_timer_in = '0;
            idle_count_in = idle_inc;
            if (column_lines != 4'd0) begin
               idle_count_in = '0;
               if (key_hit) begin
                  tones_on_in = 1'b1;
               end
            end else if (idle_inc >= idle_limit) begin
               tones_on_in = 1'b0;
            end
            if (row_select_ff == kpdtg_pkg::ROW_LAST || row_select_ff == 4'd0) begin
               row_select_in = kpdtg_pkg::ROW_FIRST;
            end else begin
               row_select_in = {row_select_ff[2:0], 1'b0};
            end
         end else begin
            scan_timer_in = scan_timer_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_select_ff <= kpdtg_pkg::ROW_RESET;
         scan_timer_ff <= '0;
         idle_count_ff <= '0;
         tones_on_ff <= 1'b0;
      end else begin
         row_select_ff <= row_select_in;
         scan_timer_ff <= scan_timer_in;
         idle_count_ff <= idle_count_in;
         tones_on_ff <= tones_on_in;
      end
   end

   always_comb begin
      scan_out.row_drive = row_select_ff;
      scan_out.key_valid = key_hit;
      scan_out.key_char = key_hit ? kpdtg_pkg::KEY_TABLE[{row_dec.index, col_dec.index}]
                          : 7'd0;
      scan_out.row_half = kpdtg_pkg::ROW_HALF_TABLE[row_dec.index];
      scan_out.column_half = kpdtg_pkg::COLUMN_HALF_TABLE[col_dec.index];
      scan_out.tone_ctrl.advance = accept && tones_on_ff;
      scan_out.tone_ctrl.update = accept && key_hit;
      scan_out.tone_ctrl.start = accept && key_hit && !tones_on_ff;
   end

endmodule

>>> tb/tb.sv
// Self-checking testbench for keypad_scan_dual_tone_generator_unit.
// Feeds column samples as timer ticks, predicts each tick's row, tone and key result,
// and checks the results in order. Depends on kpdtg_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD = 80;
   localparam int REPORT_CAP = 30;

   localparam logic [10:0] ROW_HALF [4] = '{11'd827, 11'd749, 11'd677, 11'd612};
   localparam logic [10:0] COL_HALF [4] = '{11'd1435, 11'd1299, 11'd1174, 11'd1063};
   localparam logic [7:0] KEY_ASCII [16] = '{
      "1", "2", "3", "A",
      "4", "5", "6", "B",
      "7", "8", "9", "C",
      "*", "0", "#", "D"
   };

   typedef enum int {FLOW_STEADY, FLOW_RANDOM, FLOW_BURSTY} flow_mode_type;

   typedef struct packed {
      logic [3:0] row_drive;
      logic row_tone;
      logic column_tone;
      logic key_valid;
      logic [6:0] key_char;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_column_lines = 4'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_row_drive;
   logic rsp_row_tone;
   logic rsp_column_tone;
   logic rsp_key_valid;
   logic [6:0] rsp_key_char;
   logic csr_write_enable = 1'b0;
   logic csr_index = kpdtg_pkg::CSR_SCAN_PERIOD;
   logic [15:0] csr_write_data = 16'd0;

   // Scanner and tone state as the block should hold it.
   logic [15:0] cfg_period;
   logic [3:0] cfg_idle_limit;
   logic [3:0] row_sel;
   logic [15:0] scan_count;
   logic [3:0] quiet_scans;
   logic tone_run;
   logic [10:0] row_half;
   logic [10:0] col_half;
   logic [10:0] row_cnt;
   logic [10:0] col_cnt;
   logic row_lvl;
   logic col_lvl;

   tick_result_type predicted_results [$];
   logic [3:0] column_queue [$];
   int ticks_queued = 0;
   int ticks_accepted = 0;
   int err_count = 0;
   int cycle_count = 0;
   logic req_took = 1'b0;

   flow_mode_type send_flow = FLOW_STEADY;
   flow_mode_type sink_flow = FLOW_STEADY;
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   int holds_asked = 0;
   int holds_done = 0;

   keypad_scan_dual_tone_generator_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_column_lines(req_column_lines),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_row_drive(rsp_row_drive),
      .rsp_row_tone(rsp_row_tone),
      .rsp_column_tone(rsp_column_tone),
      .rsp_key_valid(rsp_key_valid),
      .rsp_key_char(rsp_key_char),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int hot_index(input logic [3:0] v);
      case (v)
         4'b0001: return 0;
         4'b0010: return 1;
         4'b0100: return 2;
         4'b1000: return 3;
         default: return -1;
      endcase
   endfunction

   task automatic scan_tick(input logic [3:0] cols, output tick_result_type res);
      logic [3:0] driven;
      int r;
      int c;
      driven = row_sel;
      res = '0;
      res.row_drive = driven;
      if (tone_run) begin
         if (row_cnt <= 11'd1) begin
            row_lvl = ~row_lvl;
            row_cnt = row_half;
         end else begin
            row_cnt = row_cnt - 11'd1;
         end
         if (col_cnt <= 11'd1) begin
            col_lvl = ~col_lvl;
            col_cnt = col_half;
         end else begin
            col_cnt = col_cnt - 11'd1;
         end
      end
      if (int'(scan_count) + 1 >= int'(cfg_period)) begin
         scan_count = 16'd0;
         if (quiet_scans < 4'd15) quiet_scans = quiet_scans + 4'd1;
         if (cols != 4'd0) begin
            r = hot_index(driven);
            c = hot_index(cols);
            quiet_scans = 4'd0;
            if (r >= 0 && c >= 0) begin
               row_half = ROW_HALF[r];
               col_half = COL_HALF[c];
               if (!tone_run) begin
                  row_cnt = row_half;
                  col_cnt = col_half;
                  tone_run = 1'b1;
               end
               res.key_valid = 1'b1;
               res.key_char = KEY_ASCII[r * 4 + c][6:0];
            end
         end else if (quiet_scans >= cfg_idle_limit) begin
            tone_run = 1'b0;
         end
         row_sel = (driven == 4'b1000 || driven == 4'b0000) ? 4'b0001 : (driven << 1);
      end else begin
         scan_count = scan_count + 16'd1;
      end
      res.row_tone = row_lvl;
      res.column_tone = col_lvl;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         err_count++;
         if (err_count <= REPORT_CAP)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : tick_check
      tick_result_type want;
      tick_result_type got;
      if (reset) begin
         cfg_period = kpdtg_pkg::SCAN_PERIOD_RESET;
         cfg_idle_limit = kpdtg_pkg::IDLE_LIMIT_RESET;
         row_sel = 4'b0010;
         scan_count = 16'd0;
         quiet_scans = 4'd0;
         tone_run = 1'b0;
         row_half = 11'd0;
         col_half = 11'd0;
         row_cnt = 11'd0;
         col_cnt = 11'd0;
         row_lvl = 1'b0;
         col_lvl = 1'b0;
         predicted_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_row_drive, rsp_row_tone, rsp_column_tone, rsp_key_valid, rsp_key_char};
            if (predicted_results.size() == 0) begin
               err_count++;
               if (err_count <= REPORT_CAP)
                  $display("%0t: result transfer with nothing expected, got %h", $time, got);
            end else begin
               want = predicted_results.pop_front();
               check_field("row_drive", want.row_drive, got.row_drive);
               check_field("row_tone", want.row_tone, got.row_tone);
               check_field("column_tone", want.column_tone, got.column_tone);
               check_field("key_valid", want.key_valid, got.key_valid);
               check_field("key_char", want.key_char, got.key_char);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == kpdtg_pkg::CSR_SCAN_PERIOD) cfg_period = csr_write_data;
            else cfg_idle_limit = csr_write_data[3:0];
         end
         if (req_valid && req_ready) begin
            scan_tick(req_column_lines, want);
            predicted_results.push_back(want);
            ticks_accepted <= ticks_accepted + 1;
         end
      end
      req_took <= !reset && req_valid && req_ready;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, predicted_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin : tick_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (column_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_column_lines <= column_queue.pop_front();
            if (send_flow != FLOW_STEADY) begin
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = $urandom_range(1, 6);
               end
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : result_sink
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_done < holds_asked) begin
         holds_done++;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (sink_flow)
            FLOW_STEADY: rsp_ready <= 1'b1;
            FLOW_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: begin
               if ($urandom_range(0, 5) == 0) begin
                  stall_left = $urandom_range(0, 7);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   task automatic queue_tick(input logic [3:0] cols);
      column_queue.push_back(cols);
      ticks_queued++;
   endtask

   // Mostly single keys held for a while, with quiet stretches and some chord noise.
   task automatic queue_key_activity(input int count);
      int kind;
      int run;
      logic [3:0] cols;
      while (count > 0) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            cols = 4'b0001 << $urandom_range(0, 3);
            run = $urandom_range(1, 20);
         end else if (kind < 85) begin
            cols = 4'd0;
            run = $urandom_range(1, 12);
         end else begin
            cols = 4'd0;
            run = $urandom_range(1, 4);
         end
         repeat (run) begin
            if (kind >= 85) cols = 4'($urandom_range(0, 15));
            queue_tick(cols);
            count--;
         end
      end
   endtask

   task automatic settle();
      while (ticks_accepted != ticks_queued || predicted_results.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic flow_mode_type pick_flow();
      return flow_mode_type'($urandom_range(0, 2));
   endfunction

   task automatic run_phase(input logic [15:0] period, input logic [3:0] limit, input int count,
                            input flow_mode_type send_mode, input flow_mode_type sink_mode);
      settle();
      write_csr(kpdtg_pkg::CSR_SCAN_PERIOD, period);
      write_csr(kpdtg_pkg::CSR_IDLE_LIMIT, {12'($urandom_range(0, 4095)), limit});
      send_flow = send_mode;
      sink_flow = sink_mode;
      queue_key_activity(count);
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Power-up settings: no scan falls due within these ticks.
      send_flow = FLOW_BURSTY;
      sink_flow = FLOW_RANDOM;
      queue_key_activity(10);

      // Every key once, then quiet, chord and restart cases with a scan on every tick.
      settle();
      write_csr(kpdtg_pkg::CSR_SCAN_PERIOD, 16'd1);
      write_csr(kpdtg_pkg::CSR_IDLE_LIMIT, 16'd0);
      for (int i = 0; i < 16; i++) queue_tick(4'b0001 << (i / 4));
      queue_tick(4'h0);
      queue_tick(4'hF);
      queue_tick(4'h5);
      queue_tick(4'h1);
      queue_tick(4'hA);
      queue_tick(4'h0);

      // Scan on every tick with the longest idle limit, so the tones stop only after the longest quiet run.
      run_phase(16'd0, 4'd15, 120, FLOW_STEADY, FLOW_STEADY);
      settle();
      send_flow = FLOW_BURSTY;
      sink_flow = FLOW_BURSTY;
      holds_asked++;
      queue_key_activity(120);

      run_phase(16'd1, 4'd1, 50, pick_flow(), pick_flow());
      run_phase(16'd3, 4'd4, 50, pick_flow(), pick_flow());
      run_phase(16'($urandom_range(2, 12)), 4'($urandom_range(1, 14)), 50,
                pick_flow(), pick_flow());
      run_phase(16'hFFFF, 4'd15, 40, pick_flow(), pick_flow());
      run_phase(16'($urandom_range(1, 6)), 4'($urandom_range(1, 14)), 50,
                pick_flow(), FLOW_BURSTY);

      settle();
      repeat (20) @(negedge clock);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
